@@ rtl/core/pop3_user_pass_sniffer_unit_assert.svh @@
// Assertion macros for the POP3 USER/PASS sniffer.
`ifndef POP3_USER_PASS_SNIFFER_UNIT_ASSERT_SVH
`define POP3_USER_PASS_SNIFFER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define P3US_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pop3 sniffer assertion failed");
// Check that a condition in one cycle implies another in the same cycle.
`define P3US_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pop3 sniffer implication failed");
// Check that a condition implies another in the next cycle.
`define P3US_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pop3 sniffer next-cycle check failed");
`else
`define P3US_ASSERT(label, prop)
`define P3US_ASSERT_IMPLY(label, ante, cons)
`define P3US_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/pop3us_pkg.sv @@
// Shared types, constants and helper functions of the POP3 USER/PASS sniffer.
package pop3us_pkg;

  // Longest field accepted; the count width caps it at 255.
  localparam int unsigned MAX_FIELD_LEN = 255;
  localparam int unsigned FieldLimitInt = (MAX_FIELD_LEN > 255) ? 255 : MAX_FIELD_LEN;
  localparam logic [7:0] FIELD_LIMIT = 8'(FieldLimitInt);

  // Protocol characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_U  = 8'h55;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_P  = 8'h50;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] LOWER_BIT = 8'h20;

  // Parser states; bit position equals the reported state code
  typedef enum logic [15:0] {
    ST_INIT      = 16'h0001,
    ST_GOT_U     = 16'h0002,
    ST_GOT_S     = 16'h0004,
    ST_GOT_E     = 16'h0008,
    ST_GOT_R     = 16'h0010,
    ST_NAME      = 16'h0020,
    ST_NAME_CR   = 16'h0040,
    ST_NAME_DONE = 16'h0080,
    ST_GOT_P     = 16'h0100,
    ST_GOT_A     = 16'h0200,
    ST_GOT_S1    = 16'h0400,
    ST_GOT_S2    = 16'h0800,
    ST_SECRET    = 16'h1000,
    ST_SECRET_CR = 16'h2000,
    ST_DONE      = 16'h4000,
    ST_ERR       = 16'h8000
  } state_e;

  // Reported state codes used in checks
  localparam logic [3:0] CODE_NAME   = 4'd5;
  localparam logic [3:0] CODE_SECRET = 4'd12;
  localparam logic [3:0] CODE_ERR    = 4'd15;

  // Field tags
  localparam logic FIELD_USER = 1'b0;
  localparam logic FIELD_PASS = 1'b1;

  // One result beat
  typedef struct packed {
    logic [3:0] parse_state;
    logic       capture_valid;
    logic       capture_field;
    logic [7:0] capture_byte;
    logic       field_end;
    logic [7:0] field_length;
    logic       overflow;
  } result_t;

  // Match a byte against an uppercase command letter
  function automatic logic letter_is(logic [7:0] c, logic [7:0] upper, logic ignore_case);
    return (c == upper) || (ignore_case && (c == (upper | LOWER_BIT)));
  endfunction

  // Turn the one-hot state into its 4-bit code
  function automatic logic [3:0] state_code(state_e st);
    logic [3:0] code;
    code = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (st[i]) begin
        code = code | 4'(i);
      end
    end
    return code;
  endfunction

endpackage

@@ rtl/core/pop3us_fsm.sv @@
// Next-state and result logic of the sniffer for one byte.
module pop3us_fsm import pop3us_pkg::*; (
  input  state_e     state_i,
  input  logic [7:0] user_cnt_i,
  input  logic [7:0] pass_cnt_i,
  input  logic       ignore_case_i,
  input  logic [7:0] rx_byte_i,
  input  logic       restart_i,
  output state_e     state_o,
  output logic [7:0] user_cnt_o,
  output logic [7:0] pass_cnt_o,
  output result_t    result_o
);

  state_e     cur;
  state_e     nxt;
  logic [7:0] ucnt;
  logic [7:0] pcnt;
  logic [7:0] ucnt_nxt;
  logic [7:0] pcnt_nxt;
  logic       field;
  logic       cap;
  logic       fend;
  logic       ovf;

  // Apply restart ahead of the byte
  always_comb begin
    cur  = restart_i ? ST_INIT : state_i;
    ucnt = restart_i ? 8'd0 : user_cnt_i;
    pcnt = restart_i ? 8'd0 : pass_cnt_i;
  end

  // Step the parser
  always_comb begin
    nxt      = cur;
    ucnt_nxt = ucnt;
    pcnt_nxt = pcnt;
    cap      = 1'b0;
    fend     = 1'b0;
    ovf      = 1'b0;
    unique case (cur)
      ST_INIT:      nxt = letter_is(rx_byte_i, CH_U, ignore_case_i) ? ST_GOT_U : ST_INIT;
      ST_GOT_U:     nxt = letter_is(rx_byte_i, CH_S, ignore_case_i) ? ST_GOT_S : ST_ERR;
      ST_GOT_S:     nxt = letter_is(rx_byte_i, CH_E, ignore_case_i) ? ST_GOT_E : ST_ERR;
      ST_GOT_E:     nxt = letter_is(rx_byte_i, CH_R, ignore_case_i) ? ST_GOT_R : ST_ERR;
      ST_GOT_R:     nxt = (rx_byte_i == CH_SP) ? ST_NAME : ST_ERR;
      ST_NAME: begin
        if (rx_byte_i == CH_CR) begin
          fend = 1'b1;
          nxt  = ST_NAME_CR;
        end else if (ucnt >= FIELD_LIMIT) begin
          ovf = 1'b1;
          nxt = ST_ERR;
        end else begin
          ucnt_nxt = ucnt + 8'd1;
          cap      = 1'b1;
        end
      end
      ST_NAME_CR:   nxt = (rx_byte_i == CH_LF) ? ST_NAME_DONE : ST_ERR;
      ST_NAME_DONE: nxt = letter_is(rx_byte_i, CH_P, ignore_case_i) ? ST_GOT_P : ST_ERR;
      ST_GOT_P:     nxt = letter_is(rx_byte_i, CH_A, ignore_case_i) ? ST_GOT_A : ST_ERR;
      ST_GOT_A:     nxt = letter_is(rx_byte_i, CH_S, ignore_case_i) ? ST_GOT_S1 : ST_ERR;
      ST_GOT_S1:    nxt = letter_is(rx_byte_i, CH_S, ignore_case_i) ? ST_GOT_S2 : ST_ERR;
      ST_GOT_S2:    nxt = (rx_byte_i == CH_SP) ? ST_SECRET : ST_ERR;
      ST_SECRET: begin
        if (rx_byte_i == CH_CR) begin
          fend = 1'b1;
          nxt  = ST_SECRET_CR;
        end else if (pcnt >= FIELD_LIMIT) begin
          ovf = 1'b1;
          nxt = ST_ERR;
        end else begin
          pcnt_nxt = pcnt + 8'd1;
          cap      = 1'b1;
        end
      end
      ST_SECRET_CR: nxt = (rx_byte_i == CH_LF) ? ST_DONE : ST_ERR;
      ST_DONE:      nxt = ST_DONE;
      ST_ERR:       nxt = ST_ERR;
      default:      nxt = ST_ERR;
    endcase
  end

  // Password field runs from the name line end through done
  assign field = (cur == ST_NAME_DONE) || (cur == ST_GOT_P) || (cur == ST_GOT_A) ||
                 (cur == ST_GOT_S1) || (cur == ST_GOT_S2) || (cur == ST_SECRET) ||
                 (cur == ST_SECRET_CR) || (cur == ST_DONE);

  // Build the result beat; error state reports nothing but its code
  always_comb begin
    result_o.parse_state   = state_code(nxt);
    result_o.capture_valid = cap;
    result_o.capture_byte  = cap ? rx_byte_i : 8'd0;
    result_o.field_end     = fend;
    result_o.overflow      = ovf;
    if (cur == ST_ERR) begin
      result_o.capture_field = FIELD_USER;
      result_o.field_length  = 8'd0;
    end else begin
      result_o.capture_field = field;
      result_o.field_length  = field ? pcnt_nxt : ucnt_nxt;
    end
  end

  assign state_o    = nxt;
  assign user_cnt_o = ucnt_nxt;
  assign pass_cnt_o = pcnt_nxt;

endmodule

@@ rtl/core/pop3_user_pass_sniffer_unit.sv @@
// POP3 USER/PASS sniffer: one client byte in, one parse result out, each beat.
// Takes one byte per clock cycle while the result channel is not stalled; a byte
// lands in the input register, and the parser step loads the result register from
// it once the result register is free. The single parser step sits between those
// two registers, and its state feeds the next byte directly. ignore_case resets
// to 1; the user must write it with cfg_we_i only while no byte is in flight, as
// the block itself does not enforce this. Reset clears the parser to its initial
// state with both field counts at zero.
`include "pop3_user_pass_sniffer_unit_assert.svh"
module pop3_user_pass_sniffer_unit import pop3us_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       restart_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] parse_state_o,
  output logic       capture_valid_o,
  output logic       capture_field_o,
  output logic [7:0] capture_byte_o,
  output logic       field_end_o,
  output logic [7:0] field_length_o,
  output logic       overflow_o
);

  logic       ignore_case_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] rx_byte_q;
  logic       restart_q;
  logic       out_valid_q, out_valid_d;
  result_t    result_q, result_d;
  state_e     state_q, state_d;
  logic [7:0] user_cnt_q, user_cnt_d;
  logic [7:0] pass_cnt_q, pass_cnt_d;
  logic       out_ready;
  logic       in_take;
  logic       step;

  // Handshake: the result register frees when empty or taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = out_ready ? in_valid_q : out_valid_q;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_case_q <= 1'b1;
    end else if (cfg_we_i) begin
      ignore_case_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rx_byte_q <= rx_byte_i;
      restart_q <= restart_i;
    end
  end

  // Parser step
  pop3us_fsm u_fsm (
    .state_i      (state_q),
    .user_cnt_i   (user_cnt_q),
    .pass_cnt_i   (pass_cnt_q),
    .ignore_case_i(ignore_case_q),
    .rx_byte_i    (rx_byte_q),
    .restart_i    (restart_q),
    .state_o      (state_d),
    .user_cnt_o   (user_cnt_d),
    .pass_cnt_o   (pass_cnt_d),
    .result_o     (result_d)
  );

  // Advance parser state on each processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      user_cnt_q  <= 8'd0;
      pass_cnt_q  <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        state_q    <= state_d;
        user_cnt_q <= user_cnt_d;
        pass_cnt_q <= pass_cnt_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign parse_state_o   = result_q.parse_state;
  assign capture_valid_o = result_q.capture_valid;
  assign capture_field_o = result_q.capture_field;
  assign capture_byte_o  = result_q.capture_byte;
  assign field_end_o     = result_q.field_end;
  assign field_length_o  = result_q.field_length;
  assign overflow_o      = result_q.overflow;

  // Checks
  `P3US_ASSERT_IMPLY(a_capture_in_field, out_valid_q && result_q.capture_valid,
                     result_q.parse_state == CODE_NAME || result_q.parse_state == CODE_SECRET)
  `P3US_ASSERT_IMPLY(a_overflow_is_error, out_valid_q && result_q.overflow, result_q.parse_state == CODE_ERR)
  `P3US_ASSERT_NEXT(a_error_sticky, state_q == ST_ERR && !(in_valid_q && restart_q),
                    state_q == ST_ERR)
  `P3US_ASSERT_IMPLY(a_stall_needs_item, in_stall_o, in_valid_q && out_valid_q)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the POP3 USER/PASS sniffer unit.
`timescale 1ns / 100ps
module tb_top;
  import pop3us_pkg::*;

  // Parser state codes as reported on parse_state
  localparam logic [3:0] PS_INIT      = 4'd0;
  localparam logic [3:0] PS_GOT_U     = 4'd1;
  localparam logic [3:0] PS_GOT_S     = 4'd2;
  localparam logic [3:0] PS_GOT_E     = 4'd3;
  localparam logic [3:0] PS_GOT_R     = 4'd4;
  localparam logic [3:0] PS_NAME      = 4'd5;
  localparam logic [3:0] PS_NAME_CR   = 4'd6;
  localparam logic [3:0] PS_NAME_DONE = 4'd7;
  localparam logic [3:0] PS_GOT_P     = 4'd8;
  localparam logic [3:0] PS_GOT_A     = 4'd9;
  localparam logic [3:0] PS_GOT_S1    = 4'd10;
  localparam logic [3:0] PS_GOT_S2    = 4'd11;
  localparam logic [3:0] PS_SECRET    = 4'd12;
  localparam logic [3:0] PS_SECRET_CR = 4'd13;
  localparam logic [3:0] PS_DONE      = 4'd14;
  localparam logic [3:0] PS_ERR       = 4'd15;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } rx_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       restart_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [3:0] parse_state_o;
  logic       capture_valid_o;
  logic       capture_field_o;
  logic [7:0] capture_byte_o;
  logic       field_end_o;
  logic [7:0] field_length_o;
  logic       overflow_o;

  pop3_user_pass_sniffer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .parse_state_o   (parse_state_o),
    .capture_valid_o (capture_valid_o),
    .capture_field_o (capture_field_o),
    .capture_byte_o  (capture_byte_o),
    .field_end_o     (field_end_o),
    .field_length_o  (field_length_o),
    .overflow_o      (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the parser and its register
  logic       case_fold       = 1'b1;
  logic [3:0] sniff_state     = PS_INIT;
  logic [7:0] shadow_name_cnt = 8'd0;
  logic [7:0] shadow_secr_cnt = 8'd0;

  rx_beat_t   client_bytes_q[$];
  result_t    parse_results_q[$];
  logic [7:0] login_bytes[$];
  int         bytes_queued   = 0;
  int         mismatch_count = 0;
  bit         steady_run     = 1'b0;

  function automatic logic is_cmd_letter(logic [7:0] c, logic [7:0] upper);
    return (c == upper) || (case_fold && (c == (upper | LOWER_BIT)));
  endfunction

  // Advance the shadow parser by one byte and return the result it reports
  function automatic result_t parse_step(logic [7:0] c, logic rs);
    result_t    r;
    logic [3:0] prev;
    logic [3:0] nxt;
    logic [7:0] held;
    r = '0;
    if (rs) begin
      sniff_state = PS_INIT;
      shadow_name_cnt = 8'd0;
      shadow_secr_cnt = 8'd0;
    end
    prev = sniff_state;
    nxt = prev;
    r.capture_field = (prev >= PS_NAME_DONE && prev <= PS_DONE) ? FIELD_PASS : FIELD_USER;
    case (prev)
      PS_INIT:      nxt = is_cmd_letter(c, CH_U) ? PS_GOT_U : PS_INIT;
      PS_GOT_U:     nxt = is_cmd_letter(c, CH_S) ? PS_GOT_S : PS_ERR;
      PS_GOT_S:     nxt = is_cmd_letter(c, CH_E) ? PS_GOT_E : PS_ERR;
      PS_GOT_E:     nxt = is_cmd_letter(c, CH_R) ? PS_GOT_R : PS_ERR;
      PS_GOT_R:     nxt = (c == CH_SP) ? PS_NAME : PS_ERR;
      PS_NAME_CR:   nxt = (c == CH_LF) ? PS_NAME_DONE : PS_ERR;
      PS_NAME_DONE: nxt = is_cmd_letter(c, CH_P) ? PS_GOT_P : PS_ERR;
      PS_GOT_P:     nxt = is_cmd_letter(c, CH_A) ? PS_GOT_A : PS_ERR;
      PS_GOT_A:     nxt = is_cmd_letter(c, CH_S) ? PS_GOT_S1 : PS_ERR;
      PS_GOT_S1:    nxt = is_cmd_letter(c, CH_S) ? PS_GOT_S2 : PS_ERR;
      PS_GOT_S2:    nxt = (c == CH_SP) ? PS_SECRET : PS_ERR;
      PS_SECRET_CR: nxt = (c == CH_LF) ? PS_DONE : PS_ERR;
      PS_DONE:      nxt = PS_DONE;
      PS_NAME, PS_SECRET: begin
        held = (prev == PS_NAME) ? shadow_name_cnt : shadow_secr_cnt;
        if (c == CH_CR) begin
          r.field_end = 1'b1;
          nxt = (prev == PS_NAME) ? PS_NAME_CR : PS_SECRET_CR;
        end else if (held >= FIELD_LIMIT) begin
          r.overflow = 1'b1;
          nxt = PS_ERR;
        end else begin
          if (prev == PS_NAME) begin
            shadow_name_cnt = shadow_name_cnt + 8'd1;
          end else begin
            shadow_secr_cnt = shadow_secr_cnt + 8'd1;
          end
          r.capture_valid = 1'b1;
          r.capture_byte = c;
        end
      end
      default:      nxt = PS_ERR;
    endcase
    sniff_state = nxt;
    r.parse_state = nxt;
    // Error state reports nothing but its code
    if (prev == PS_ERR) begin
      r.capture_field = FIELD_USER;
      r.field_length = 8'd0;
    end else begin
      r.field_length = r.capture_field ? shadow_secr_cnt : shadow_name_cnt;
    end
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic compare_field(string name, logic [7:0] want_v, logic [7:0] seen_v);
    if (want_v !== seen_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, seen_v);
      mismatch_count++;
    end
  endtask

  task automatic queue_byte(logic [7:0] b, logic rs);
    client_bytes_q.push_back('{data: b, restart: rs});
    bytes_queued++;
  endtask

  task automatic queue_text(string s, logic rs_first);
    for (int i = 0; i < s.len(); i++) begin
      queue_byte(s[i], rs_first && (i == 0));
    end
  endtask

  // Append a command word, folding letters to lowercase now and then
  task automatic append_command(string word);
    logic [7:0] ch;
    int         lower_pct;
    lower_pct = case_fold ? 30 : 3;
    for (int i = 0; i < word.len(); i++) begin
      ch = word[i];
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 99) < lower_pct) begin
        ch = ch | LOWER_BIT;
      end
      login_bytes.push_back(ch);
    end
  endtask

  task automatic append_field(int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom()); while (b == CH_CR);
      login_bytes.push_back(b);
    end
  endtask

  // Queue a USER/PASS exchange with random field content and done-state trailer
  task automatic queue_login(int name_len, int secret_len, bit corrupt, bit first_restart);
    int spot;
    login_bytes.delete();
    append_command("USER ");
    append_field(name_len);
    login_bytes.push_back(CH_CR);
    login_bytes.push_back(CH_LF);
    append_command("PASS ");
    append_field(secret_len);
    login_bytes.push_back(CH_CR);
    login_bytes.push_back(CH_LF);
    spot = $urandom_range(0, 3);
    for (int i = 0; i < spot; i++) begin
      login_bytes.push_back(8'($urandom()));
    end
    if (corrupt) begin
      spot = $urandom_range(0, login_bytes.size() - 1);
      login_bytes[spot] = 8'($urandom());
    end
    for (int i = 0; i < login_bytes.size(); i++) begin
      queue_byte(login_bytes[i], (i == 0) ? first_restart : ($urandom_range(0, 199) == 0));
    end
  endtask

  function automatic int field_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, 40);
    return $urandom_range(0, 12);
  endfunction

  task automatic queue_random_session();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        queue_byte(8'($urandom()), $urandom_range(0, 9) == 0);
      end
    end else begin
      queue_login(field_len(), field_len(), kind < 30, $urandom_range(0, 6) != 0);
    end
  endtask

  // Hold off until every byte is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (client_bytes_q.size() != 0 || in_valid_i || parse_results_q.size() != 0);
  endtask

  task automatic set_case_fold(logic v);
    case_fold = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drive client bytes, predicting each result as its beat is taken
  int       send_gap = 0;
  rx_beat_t next_beat;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
      restart_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_results_q.push_back(parse_step(rx_byte_i, restart_i));
        send_gap = pick_gap();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (client_bytes_q.size() != 0) begin
          next_beat = client_bytes_q.pop_front();
          in_valid_i <= 1'b1;
          rx_byte_i <= next_beat.data;
          restart_i <= next_beat.restart;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Take result beats, compare with the oldest prediction, stall at random
  int      stall_left = 0;
  result_t seen;
  result_t want;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen.parse_state   = parse_state_o;
        seen.capture_valid = capture_valid_o;
        seen.capture_field = capture_field_o;
        seen.capture_byte  = capture_byte_o;
        seen.field_end     = field_end_o;
        seen.field_length  = field_length_o;
        seen.overflow      = overflow_o;
        if (parse_results_q.size() == 0) begin
          $display("%0t ns: result beat with none expected, state %0h", $time, parse_state_o);
          mismatch_count++;
        end else begin
          want = parse_results_q.pop_front();
          compare_field("parse_state", 8'(want.parse_state), 8'(seen.parse_state));
          compare_field("capture_valid", 8'(want.capture_valid), 8'(seen.capture_valid));
          compare_field("capture_field", 8'(want.capture_field), 8'(seen.capture_field));
          compare_field("capture_byte", want.capture_byte, seen.capture_byte);
          compare_field("field_end", 8'(want.field_end), 8'(seen.field_end));
          compare_field("field_length", want.field_length, seen.field_length);
          compare_field("overflow", 8'(want.overflow), 8'(seen.overflow));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Stimulus phases
  initial begin
    int random_start;
    int phase_end;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Mixed-case login with extreme field bytes, empty secret, done and error
    set_case_fold(1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_text("uSeR ", 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_CR, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_text("PaSs ", 1'b0);
    queue_byte(CH_CR, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_U, 1'b0);
    queue_text("UX", 1'b1);
    queue_byte(8'hFF, 1'b0);
    wait_drained();

    // Uppercase only: lowercase u is ignored in init, lowercase e is an error
    set_case_fold(1'b0);
    queue_text("uUSer", 1'b1);
    queue_text("USER \r\nPASS \r\n", 1'b1);
    wait_drained();

    // Full-length name, secret overrun, then name overrun
    set_case_fold(1'b1);
    queue_login(255, 256, 1'b0, 1'b1);
    queue_login(256, 3, 1'b0, 1'b1);
    wait_drained();

    // Random sessions in phases, register and idling changed between phases
    random_start = bytes_queued;
    while (bytes_queued - random_start < 200) begin
      steady_run = ($urandom_range(0, 3) == 0);
      set_case_fold($urandom_range(0, 1) == 1);
      phase_end = bytes_queued + 70;
      while (bytes_queued < phase_end) begin
        queue_random_session();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS pop3_user_pass_sniffer_unit");
    end else begin
      $display("FAIL pop3_user_pass_sniffer_unit");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #10_000_000;
    $display("FAIL pop3_user_pass_sniffer_unit");
    $finish;
  end

endmodule
